>>> hdl/gdh_pkg.sv
// shared types and constants for the grid density histogram
package gdh_pkg;

  localparam int POS_W   = 24;
  localparam int CNT_W   = 16;
  localparam int DENS_W  = 17;
  localparam int CSZ_W   = 16;
  localparam int GRID_W  = 7;
  localparam int QIDX_W  = 6;
  localparam int FUNC_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int STEP_W  = 5;

  // function codes
  localparam logic [FUNC_W-1:0] FN_ADD   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_QUERY = 2'd1;
  localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARSE    = 2'd3;

  localparam logic [CSZ_W-1:0]   CELL_SIZE_RST = 16'd256;
  localparam logic [GRID_W-1:0]  WIDTH_RST     = 7'd64;
  localparam logic [GRID_W-1:0]  HEIGHT_RST    = 7'd64;
  localparam logic [DENS_W-1:0]  SPARSE_RST    = 17'd6554;

  localparam logic [DENS_W-1:0]  DENS_ONE      = 17'h10000;
  localparam logic [CNT_W-1:0]   CNT_SAT       = 16'hFFFF;

  // divider step counts: full position magnitude, and 17 quotient bits for density
  localparam logic [STEP_W-1:0]  STEPS_POS     = 5'd24;
  localparam logic [STEP_W-1:0]  STEPS_DENS    = 5'd17;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_XDIV,
    ST_XWAIT,
    ST_YDIV,
    ST_YWAIT,
    ST_READ,
    ST_UPDATE,
    ST_QLOAD,
    ST_QDIV,
    ST_QWAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [CNT_W-1:0]  rem_init;
    logic [POS_W-1:0]  dividend;
    logic [STEP_W-1:0] steps;
    logic [CNT_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] quot;
  } div_rsp_t;

endpackage

>>> hdl/gdh_div.sv
// shared restoring divider, one quotient bit per cycle
module gdh_div (
  input  logic              clk,
  input  logic              rst_n,
  input  gdh_pkg::div_req_t req,
  output gdh_pkg::div_rsp_t rsp
);
  import gdh_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] left_r;
  logic [CNT_W-1:0]  rem_r;
  logic [POS_W-1:0]  shf_r;
  logic [POS_W-1:0]  quo_r;
  logic [CNT_W-1:0]  dvs_r;

  logic [CNT_W:0]    part;
  logic [CNT_W-1:0]  diff;
  logic              fits;

  // remainder stays below the divisor, so the low bits of the difference are exact
  assign part = {rem_r, shf_r[POS_W-1]};
  assign diff = part[CNT_W-1:0] - dvs_r;
  assign fits = part >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      left_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        left_r <= req.steps;
      end else if (busy_r) begin
        left_r <= left_r - 1'b1;
        if (left_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.rem_init;
      shf_r <= req.dividend;
      dvs_r <= req.divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? diff : part[CNT_W-1:0];
      shf_r <= {shf_r[POS_W-2:0], 1'b0};
      quo_r <= {quo_r[POS_W-2:0], fits};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

>>> hdl/gdh_store.sv
// cell count memory, one write port and one registered read port
module gdh_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [gdh_pkg::CNT_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [gdh_pkg::CNT_W-1:0] rdata
);
  import gdh_pkg::*;

  logic [CNT_W-1:0] mem [DEPTH];
  logic [CNT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/grid_density_histogram_sparse_cells_unit.sv
// grid density histogram: top level with sequencer, config registers and result register
// add item: divisions of x and then y by the cell size, then read-modify-write; dropped if either coordinate is off the grid
// query item: count read, then a division by the maximum; no division when the maximum is zero, no read when off the store
// clear item: every memory entry zeroed, one per cycle; unused code: result only, no other work
// one item at a time, next can be taken in the cycle out_valid rises; a taken item waits while the prior result is held
// reset (rst_n low, synchronous) starts a clearing pass over every memory entry; no item meanwhile
module grid_density_histogram_sparse_cells_unit #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [gdh_pkg::FUNC_W-1:0]     in_func,
  input  logic signed [gdh_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [gdh_pkg::POS_W-1:0] in_pos_y,
  input  logic [gdh_pkg::QIDX_W-1:0]     in_query_col,
  input  logic [gdh_pkg::QIDX_W-1:0]     in_query_row,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_accepted,
  output logic [gdh_pkg::CNT_W-1:0]      out_cell_count,
  output logic [gdh_pkg::DENS_W-1:0]     out_density,
  output logic                           out_sparse,
  input  logic                           cfg_we,
  input  logic [gdh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gdh_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import gdh_pkg::*;

  localparam int DEPTH   = MAX_ROWS * MAX_COLS;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COL_LIM = (MAX_COLS > 127) ? 127 : MAX_COLS;
  localparam int ROW_LIM = (MAX_ROWS > 127) ? 127 : MAX_ROWS;
  localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);
  localparam logic [AW-1:0] COL_STRIDE = AW'(MAX_COLS);

  state_t state_r, state_nxt;

  // configuration
  logic [CSZ_W-1:0]  cfg_csz_r;
  logic [GRID_W-1:0] cfg_width_r;
  logic [GRID_W-1:0] cfg_height_r;
  logic [DENS_W-1:0] cfg_sparse_r;

  // item context
  logic [FUNC_W-1:0] func_r;
  logic [POS_W-1:0]  posx_r;
  logic [POS_W-1:0]  posy_r;
  logic [GRID_W-1:0] cx_r;
  logic [AW-1:0]     addr_r;
  logic [AW-1:0]     clr_addr_r;
  logic              clr_item_r;
  logic [CNT_W-1:0]  max_cnt_r;

  // pending result
  logic              acc_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DENS_W-1:0] dens_r;

  logic              out_valid_r;
  logic              out_acc_r;
  logic [CNT_W-1:0]  out_cnt_r;
  logic [DENS_W-1:0] out_dens_r;
  logic              out_sparse_r;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CNT_W-1:0]  mem_wdata;
  logic              mem_re;
  logic [CNT_W-1:0]  mem_rdata;

  logic              in_beat;
  logic              out_free;
  logic              query_in_store;
  logic [GRID_W-1:0] wl;
  logic [GRID_W-1:0] hl;
  logic [CSZ_W-1:0]  divisor_pos;
  logic [POS_W-1:0]  mag_x;
  logic [POS_W-1:0]  mag_y;
  logic              coord_neg;
  logic [GRID_W-1:0] coord_lim;
  logic              coord_ok;
  logic [AW-1:0]     cell_addr;
  logic [AW-1:0]     query_addr;
  logic [CNT_W-1:0]  cnt_inc;
  logic [DENS_W-1:0] dens_clamped;

  assign in_beat  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign wl = (cfg_width_r  > GRID_W'(COL_LIM)) ? GRID_W'(COL_LIM) : cfg_width_r;
  assign hl = (cfg_height_r > GRID_W'(ROW_LIM)) ? GRID_W'(ROW_LIM) : cfg_height_r;
  assign divisor_pos = (cfg_csz_r == '0) ? CSZ_W'(1) : cfg_csz_r;

  assign mag_x = posx_r[POS_W-1] ? (~posx_r + 1'b1) : posx_r;
  assign mag_y = posy_r[POS_W-1] ? (~posy_r + 1'b1) : posy_r;

  // negative coordinates only land in cell zero
  assign coord_neg = (state_r == ST_XWAIT) ? posx_r[POS_W-1] : posy_r[POS_W-1];
  assign coord_lim = (state_r == ST_XWAIT) ? wl : hl;
  assign coord_ok  = !(coord_neg && (div_rsp.quot != '0)) &&
                     (div_rsp.quot < POS_W'(coord_lim));

  assign cell_addr  = AW'(div_rsp.quot[GRID_W-1:0]) * COL_STRIDE + AW'(cx_r);
  assign query_addr = AW'(in_query_row) * COL_STRIDE + AW'(in_query_col);
  assign query_in_store = (11'(in_query_col) < 11'(MAX_COLS)) &&
                          (11'(in_query_row) < 11'(MAX_ROWS));

  assign cnt_inc = (mem_rdata == CNT_SAT) ? mem_rdata : mem_rdata + 1'b1;
  assign dens_clamped = (div_rsp.quot > POS_W'(DENS_ONE)) ? DENS_ONE
                                                          : div_rsp.quot[DENS_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = clr_item_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (in_func)
            FN_ADD:   state_nxt = ST_XDIV;
            FN_QUERY: state_nxt = query_in_store ? ST_READ : ST_QDIV;
            FN_CLEAR: state_nxt = ST_CLEAR;
            default:  state_nxt = ST_DONE;
          endcase
        end
      end
      ST_XDIV:  state_nxt = ST_XWAIT;
      ST_XWAIT: begin
        if (div_rsp.done) begin
          state_nxt = coord_ok ? ST_YDIV : ST_DONE;
        end
      end
      ST_YDIV:  state_nxt = ST_YWAIT;
      ST_YWAIT: begin
        if (div_rsp.done) begin
          state_nxt = coord_ok ? ST_READ : ST_DONE;
        end
      end
      ST_READ:   state_nxt = (func_r == FN_ADD) ? ST_UPDATE : ST_QLOAD;
      ST_UPDATE: state_nxt = ST_DONE;
      ST_QLOAD:  state_nxt = ST_QDIV;
      ST_QDIV:   state_nxt = (max_cnt_r == '0) ? ST_DONE : ST_QWAIT;
      ST_QWAIT: begin
        if (div_rsp.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready         = 1'b0;
    div_req.start    = 1'b0;
    div_req.rem_init = '0;
    div_req.dividend = mag_x;
    div_req.steps    = STEPS_POS;
    div_req.divisor  = divisor_pos;
    mem_we           = 1'b0;
    mem_waddr        = addr_r;
    mem_wdata        = cnt_inc;
    mem_re           = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = '0;
      end
      ST_IDLE: in_ready = 1'b1;
      ST_XDIV: div_req.start = 1'b1;
      ST_YDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = mag_y;
      end
      ST_READ:   mem_re = 1'b1;
      ST_UPDATE: mem_we = 1'b1;
      ST_QDIV: begin
        // (cnt << 16) / max with the top bits preloaded; cnt never exceeds max
        div_req.start    = (max_cnt_r != '0);
        div_req.rem_init = {1'b0, cnt_r[CNT_W-1:1]};
        div_req.dividend = {cnt_r[0], {(POS_W-1){1'b0}}};
        div_req.steps    = STEPS_DENS;
        div_req.divisor  = max_cnt_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_csz_r    <= CELL_SIZE_RST;
      cfg_width_r  <= WIDTH_RST;
      cfg_height_r <= HEIGHT_RST;
      cfg_sparse_r <= SPARSE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CELL_SIZE: cfg_csz_r    <= cfg_wdata[CSZ_W-1:0];
        CFG_WIDTH:     cfg_width_r  <= cfg_wdata[GRID_W-1:0];
        CFG_HEIGHT:    cfg_height_r <= cfg_wdata[GRID_W-1:0];
        CFG_SPARSE:    cfg_sparse_r <= cfg_wdata[DENS_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      clr_item_r  <= 1'b0;
      max_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_beat) begin
        clr_item_r <= (in_func == FN_CLEAR);
        if (in_func == FN_CLEAR) begin
          max_cnt_r <= '0;
        end
      end
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= (clr_addr_r == LAST_ADDR) ? '0 : clr_addr_r + 1'b1;
      end
      if (state_r == ST_UPDATE && cnt_inc > max_cnt_r) begin
        max_cnt_r <= cnt_inc;
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item context and result payload
  always_ff @(posedge clk) begin
    if (in_beat) begin
      func_r <= in_func;
      posx_r <= in_pos_x;
      posy_r <= in_pos_y;
      addr_r <= query_addr;
      acc_r  <= 1'b0;
      cnt_r  <= '0;
      dens_r <= '0;
    end
    if (state_r == ST_XWAIT && div_rsp.done) begin
      cx_r <= div_rsp.quot[GRID_W-1:0];
    end
    if (state_r == ST_YWAIT && div_rsp.done) begin
      addr_r <= cell_addr;
    end
    if (state_r == ST_UPDATE) begin
      acc_r <= 1'b1;
    end
    if (state_r == ST_QLOAD) begin
      cnt_r <= mem_rdata;
    end
    if (state_r == ST_QWAIT && div_rsp.done) begin
      dens_r <= dens_clamped;
    end
    if (state_r == ST_DONE && out_free) begin
      out_acc_r    <= acc_r;
      out_cnt_r    <= cnt_r;
      out_dens_r   <= dens_r;
      out_sparse_r <= (func_r == FN_QUERY) && (dens_r < cfg_sparse_r);
    end
  end

  gdh_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  gdh_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (addr_r),
    .rdata (mem_rdata)
  );

  assign out_valid      = out_valid_r;
  assign out_accepted   = out_acc_r;
  assign out_cell_count = out_cnt_r;
  assign out_density    = out_dens_r;
  assign out_sparse     = out_sparse_r;

endmodule
